// ===== rtl/core/spring_damper_follower_core_macros.svh =====
// Assertion macros for the spring-damper follower.
// Expects signals named clk and rst in the scope of use.
`ifndef SPRING_DAMPER_FOLLOWER_CORE_MACROS_SVH
`define SPRING_DAMPER_FOLLOWER_CORE_MACROS_SVH

// Same-cycle implication
`define SDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sdf_pkg.sv =====
// Shared constants and types for the spring-damper follower.
// No dependencies.
`default_nettype none
package sdf_pkg;

  localparam int AXES_MAX      = 3;
  localparam int AXES_DEF      = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_FRAC       = 16;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 192;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HELD_K  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HELD_C  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REL_K   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REL_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXC_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIM = 3'd5;

  typedef struct packed {
    logic step_go;
    logic scale_go;
  } lane_cmd_t;

  typedef struct packed {
    logic done;
    logic over;
  } merge_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdf_lane.sv =====
// One axis of the follower: target, spring-damper force, Euler update,
// snap to rest, and the divider for the magnitude scaling. Uses sdf_pkg.
`default_nettype none
module sdf_lane #(
  parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  sdf_pkg::lane_cmd_t    cmd,
  input  wire                   held,
  input  wire signed [31:0]     delta,
  input  wire        [15:0]     dt,
  input  wire        [31:0]     k,
  input  wire        [31:0]     c,
  input  wire        [30:0]     lim,
  input  wire        [30:0]     cap,
  input  wire        [31:0]     mag,
  output logic                  busy,
  output logic signed [31:0]    acc,
  output logic signed [31:0]    pos,
  output logic signed [31:0]    vel
);
  import sdf_pkg::*;

  localparam logic [31:0] ACC_EPS =
    32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [31:0] VEL_EPS =
    32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  typedef enum logic [4:0] {
    L_IDLE, L_TGT, L_DIFF, L_K0, L_K1, L_C0, L_C1, L_C2, L_FORCE,
    L_VMUL, L_VEL, L_PMUL, L_POS, L_SNAP, L_SC0, L_SC1, L_SC2, L_DIV
  } lstate_t;

  lstate_t            state;
  logic signed [31:0] target;
  logic signed [31:0] force_q;
  logic        [32:0] md;
  logic               sd;
  logic        [32:0] mv;
  logic               sv;
  logic        [48:0] p;
  logic        [64:0] accw;
  logic signed [65:0] t1;
  logic signed [65:0] t2;
  logic        [31:0] rem;
  logic        [30:0] quo;
  logic        [4:0]  cnt;

  logic        [32:0] mul_a;
  logic        [15:0] mul_b;
  logic signed [33:0] tsum;
  logic signed [33:0] lim34;
  logic signed [32:0] d33;
  logic signed [32:0] v33;
  logic        [64:0] rn;
  logic signed [65:0] f66;
  logic signed [65:0] cap66;
  logic        [31:0] fabs;
  logic        [31:0] vabs;
  logic        [31:0] aabs;
  logic        [33:0] r16;
  logic signed [34:0] vsum;
  logic signed [34:0] psum;
  logic        [64:0] num;
  logic        [32:0] trial;
  logic        [32:0] tdiff;
  logic        [30:0] quo_next;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    if (x > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  always_comb begin
    fabs = force_q[31] ? 32'(-force_q) : 32'(force_q);
    vabs = vel[31] ? 32'(-vel) : 32'(vel);
    aabs = acc[31] ? 32'(-acc) : 32'(acc);
    tsum = 34'(target) + 34'(delta);
    lim34 = $signed({3'b000, lim});
    d33 = 33'(target) - 33'(pos);
    v33 = 33'(vel);
    rn = (accw + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    cap66 = $signed({35'd0, cap});
    f66 = t1 - t2;
    r16 = 34'((p + (49'd1 << (DT_FRAC - 1))) >> DT_FRAC);
    vsum = 35'(vel) + (force_q[31] ? -$signed({1'b0, r16}) : $signed({1'b0, r16}));
    psum = 35'(pos) + (vel[31] ? -$signed({1'b0, r16}) : $signed({1'b0, r16}));
    num = accw + (65'(p) << 16);
    trial = {rem, quo[30]};
    tdiff = trial - {1'b0, mag};
    quo_next = {quo[29:0], (trial >= {1'b0, mag})};
    mul_a = '0;
    mul_b = '0;
    case (state)
      L_K0:    begin mul_a = md; mul_b = k[15:0]; end
      L_K1:    begin mul_a = md; mul_b = k[31:16]; end
      L_C0:    begin mul_a = mv; mul_b = c[15:0]; end
      L_C1:    begin mul_a = mv; mul_b = c[31:16]; end
      L_VEL:   begin mul_a = {1'b0, fabs}; mul_b = dt; end
      L_POS:   begin mul_a = {1'b0, vabs}; mul_b = dt; end
      L_SC0:   begin mul_a = {1'b0, aabs}; mul_b = cap[15:0]; end
      L_SC1:   begin mul_a = {1'b0, aabs}; mul_b = {1'b0, cap[30:16]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign busy = (state != L_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      target <= '0;
      pos    <= '0;
      vel    <= '0;
      acc    <= '0;
    end else begin
      p <= 49'(mul_a) * 49'(mul_b);
      case (state)
        L_IDLE: begin
          if (cmd.step_go) begin
            state <= L_TGT;
          end else if (cmd.scale_go) begin
            state <= L_SC0;
          end
        end
        L_TGT: begin
          if (!held) begin
            target <= '0;
          end else if (tsum > lim34) begin
            target <= 32'(lim34);
          end else if (tsum < -lim34) begin
            target <= 32'(-lim34);
          end else begin
            target <= tsum[31:0];
          end
          state <= L_DIFF;
        end
        L_DIFF: begin
          md    <= d33[32] ? 33'(-d33) : 33'(d33);
          sd    <= d33[32];
          mv    <= v33[32] ? 33'(-v33) : 33'(v33);
          sv    <= v33[32];
          state <= L_K0;
        end
        L_K0: state <= L_K1;
        L_K1: begin
          accw  <= 65'(p);
          state <= L_C0;
        end
        L_C0: begin
          accw  <= accw + (65'(p) << 16);
          state <= L_C1;
        end
        L_C1: begin
          t1    <= sd ? -$signed({1'b0, rn}) : $signed({1'b0, rn});
          accw  <= 65'(p);
          state <= L_C2;
        end
        L_C2: begin
          accw  <= accw + (65'(p) << 16);
          state <= L_FORCE;
        end
        L_FORCE: begin
          t2    <= sv ? -$signed({1'b0, rn}) : $signed({1'b0, rn});
          state <= L_VMUL;
        end
        L_VMUL: begin
          // clamp to the acceleration cap
          if (f66 > cap66) begin
            force_q <= 32'(cap66);
          end else if (f66 < -cap66) begin
            force_q <= 32'(-cap66);
          end else begin
            force_q <= f66[31:0];
          end
          state <= L_VEL;
        end
        L_VEL: state <= L_PMUL;
        L_PMUL: begin
          vel   <= sat32(vsum);
          state <= L_POS;
        end
        L_POS: state <= L_SNAP;
        L_SNAP: begin
          if (!held && fabs < ACC_EPS && vabs < VEL_EPS) begin
            acc <= '0;
            vel <= '0;
            pos <= '0;
          end else begin
            acc <= force_q;
            pos <= sat32(psum);
          end
          state <= L_IDLE;
        end
        L_SC0: state <= L_SC1;
        L_SC1: begin
          accw  <= 65'(p);
          state <= L_SC2;
        end
        L_SC2: begin
          // quotient fits 31 bits, so the top part already sits below mag
          rem   <= num[62:31];
          quo   <= num[30:0];
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= (trial >= {1'b0, mag}) ? tdiff[31:0] : trial[31:0];
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            acc   <= acc[31] ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sdf_merge.sv =====
// Merging stage: sum of squared lane accelerations, compare with the cap,
// and a bit-pair integer square root. Uses sdf_pkg.
`default_nettype none
module sdf_merge #(
  parameter int AXES = sdf_pkg::AXES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 go,
  input  wire        [30:0]   cap,
  input  wire signed [31:0]   lane_acc [sdf_pkg::AXES_MAX],
  output sdf_pkg::merge_sts_t sts,
  output logic       [31:0]   mag
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_SQ, M_CAP, M_CMP, M_SQRT} mstate_t;

  mstate_t     state;
  logic [1:0]  idx;
  logic [61:0] sq;
  logic [63:0] sum;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [31:0] aabs;
  logic [63:0] rb;

  always_comb begin
    aabs = lane_acc[idx][31] ? 32'(-lane_acc[idx]) : 32'(lane_acc[idx]);
    rb   = res + bitv;
  end

  assign mag = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      sts.done <= 1'b0;
      sts.over <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          sts.done <= 1'b0;
          if (go) begin
            sum   <= '0;
            sq    <= '0;
            idx   <= '0;
            state <= M_SQ;
          end
        end
        M_SQ: begin
          sts.done <= 1'b0;
          sq  <= 62'(aabs[30:0]) * 62'(aabs[30:0]);
          sum <= sum + 64'(sq);
          if (idx == 2'(AXES - 1)) begin
            state <= M_CAP;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        M_CAP: begin
          sts.done <= 1'b0;
          sq    <= 62'(cap) * 62'(cap);
          sum   <= sum + 64'(sq);
          state <= M_CMP;
        end
        M_CMP: begin
          sts.over <= (sum > 64'(sq));
          sts.done <= !(sum > 64'(sq));
          if (sum > 64'(sq)) begin
            v     <= sum;
            res   <= '0;
            bitv  <= 64'd1 << 62;
            state <= M_SQRT;
          end else begin
            state <= M_IDLE;
          end
        end
        M_SQRT: begin
          if (v >= rb) begin
            v   <= v - rb;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv     <= bitv >> 2;
          sts.done <= (bitv == 64'd1);
          if (bitv == 64'd1) begin
            state <= M_IDLE;
          end
        end
        default: begin
          sts.done <= 1'b0;
          state    <= M_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spring_damper_follower_core.sv =====
// Top level of the spring-damper follower: stream ports, configuration
// registers, sequencing of lanes and merge stage. Uses sdf_pkg, sdf_lane, sdf_merge.
`default_nettype none
`include "spring_damper_follower_core_macros.svh"
// A hand-driven follower: each item moves a per-axis target, and one lane per axis
// runs a spring-damper step with semi-implicit Euler in saturating Q.F fixed point.
// An item with a non-zero step time runs the lane steps on the shared per-lane 33x16
// multiplier, then squares and compare; when the acceleration vector exceeds the cap
// it is also scaled (32 square-root iterations, then a 31-step divide in every lane
// at once). A zero step time skips the lanes and the merge stage. A new item is
// taken while the last result still waits in the output register. No clearing
// pass after reset.
module spring_damper_follower_core #(
  parameter int AXES      = sdf_pkg::AXES_DEF,
  parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // delta_x, delta_y, delta_z, step_time
  input  wire        [sdf_pkg::IN_DATA_W-1:0] s_tdata,
  // held
  input  wire        [0:0]                    s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // accel_x, accel_y, accel_z, pos_x, pos_y, pos_z
  output logic      [sdf_pkg::OUT_DATA_W-1:0] m_tdata,
  // at_rest
  output logic       [0:0]                    m_tuser,
  input  wire                                 cfg_we,
  input  wire        [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire       [sdf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_STEP, T_MERGE, T_SCALE, T_OUT} tstate_t;

  tstate_t            state;
  logic        [31:0] held_k;
  logic        [31:0] held_c;
  logic        [31:0] rel_k;
  logic        [31:0] rel_c;
  logic        [30:0] exc_lim;
  logic        [30:0] acc_lim;
  logic signed [31:0] delta [AXES_MAX];
  logic               held;
  logic        [15:0] dt;

  lane_cmd_t          cmd;
  merge_sts_t         msts;
  logic        [31:0] mag;
  logic        [AXES_MAX-1:0] lane_busy;
  logic signed [31:0] lane_acc [AXES_MAX];
  logic signed [31:0] lane_pos [AXES_MAX];
  logic signed [31:0] lane_vel [AXES_MAX];
  logic               accept;
  logic               merge_go;
  logic               rest;

  assign s_tready = (state == T_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.step_go  = accept && (s_tdata[111:96] != 16'd0);
    cmd.scale_go = (state == T_MERGE) && msts.done && msts.over;
    merge_go     = (state == T_STEP) && (lane_busy == '0);
    rest         = 1'b1;
    for (int a = 0; a < AXES_MAX; a++) begin
      if (lane_pos[a] != 32'sd0 || lane_vel[a] != 32'sd0 || lane_acc[a] != 32'sd0) begin
        rest = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_k  <= '0;
      held_c  <= '0;
      rel_k   <= '0;
      rel_c   <= '0;
      exc_lim <= '0;
      acc_lim <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HELD_K:  held_k  <= cfg_data;
        REG_HELD_C:  held_c  <= cfg_data;
        REG_REL_K:   rel_k   <= cfg_data;
        REG_REL_C:   rel_c   <= cfg_data;
        REG_EXC_LIM: exc_lim <= cfg_data[30:0];
        REG_ACC_LIM: acc_lim <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != T_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            delta[0] <= s_tdata[31:0];
            delta[1] <= s_tdata[63:32];
            delta[2] <= s_tdata[95:64];
            held     <= s_tuser[0];
            dt       <= s_tdata[111:96];
            state    <= cmd.step_go ? T_STEP : T_OUT;
          end
        end
        T_STEP: begin
          if (merge_go) begin
            state <= T_MERGE;
          end
        end
        T_MERGE: begin
          if (msts.done) begin
            state <= msts.over ? T_SCALE : T_OUT;
          end
        end
        T_SCALE: begin
          if (lane_busy == '0) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {lane_pos[2], lane_pos[1], lane_pos[0],
                         lane_acc[2], lane_acc[1], lane_acc[0]};
            m_tuser  <= rest;
            m_tvalid <= 1'b1;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  for (genvar a = 0; a < AXES_MAX; a++) begin : g_lane
    if (a < AXES) begin : g_used
      sdf_lane #(
        .FRAC_BITS(FRAC_BITS)
      ) u_lane (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .held  (held),
        .delta (delta[a]),
        .dt    (dt),
        .k     (held ? held_k : rel_k),
        .c     (held ? held_c : rel_c),
        .lim   (exc_lim),
        .cap   (acc_lim),
        .mag   (mag),
        .busy  (lane_busy[a]),
        .acc   (lane_acc[a]),
        .pos   (lane_pos[a]),
        .vel   (lane_vel[a])
      );
    end else begin : g_unused
      assign lane_busy[a] = 1'b0;
      assign lane_acc[a]  = '0;
      assign lane_pos[a]  = '0;
      assign lane_vel[a]  = '0;
    end
  end

  sdf_merge #(
    .AXES(AXES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .go       (merge_go),
    .cap      (acc_lim),
    .lane_acc (lane_acc),
    .sts      (msts),
    .mag      (mag)
  );

  `SDF_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "item taken while busy")
  `SDF_ASSERT_NOW(a_lanes_in_window, lane_busy != '0,
    state == T_STEP || state == T_SCALE, "lane running outside its window")
  `SDF_ASSERT_NOW(a_rest_means_zero, m_tvalid && m_tuser[0], m_tdata == '0,
    "at_rest with non-zero fields")
  `SDF_ASSERT_NOW(a_scale_only_over, cmd.scale_go, msts.over,
    "scaling started below the cap")

endmodule
`default_nettype wire

// ===== tb/spring_damper_follower_core_tb.sv =====
// Self-checking testbench for spring_damper_follower_core: directed table then random items,
// every result checked against a fixed-point predictor. Depends on sdf_pkg and the core.
`timescale 1ns / 100ps
module spring_damper_follower_core_tb;
  import sdf_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [31:0] dx, dy, dz;
    logic               held;
    logic [15:0]        dt;
    logic               known;
    logic [31:0]        ax, ay, az, px, py, pz;
    logic               rest;
  } row_t;

  typedef struct {
    logic [31:0] acc [3];
    logic [31:0] pos [3];
    logic        rest;
  } motion_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_we = 0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tready, m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  spring_damper_follower_core DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state and configuration
  logic [31:0] k_held, c_held, k_rel, c_rel, exc_lim, acc_lim;
  longint tgt [3], fpos [3], fvel [3], facc [3];
  motion_t pending [$];
  int errors = 0, idle_cycles = 0;
  bit stall_long = 0, draining = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rounded product of magnitudes; 128-bit working width avoids overflow
  function automatic longint rmul(longint a, longint unsigned b, int sh);
    logic [127:0] p;
    p = 128'(a < 0 ? -a : a);
    p = p * b;
    p = (p + (128'd1 << (sh - 1))) >> sh;
    return a < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      REG_HELD_K:  k_held = v;
      REG_HELD_C:  c_held = v;
      REG_REL_K:   k_rel = v;
      REG_REL_C:   c_rel = v;
      REG_EXC_LIM: exc_lim = {1'b0, v[30:0]};
      REG_ACC_LIM: acc_lim = {1'b0, v[30:0]};
      default: ;
    endcase
  endfunction

  function automatic motion_t advance_follower(longint dd [3], logic held, logic [15:0] dt);
    motion_t r;
    longint unsigned k, c, sq, m, mag;
    longint frc, lim, cap;
    if (dt != 0) begin
      k = held ? k_held : k_rel;
      c = held ? c_held : c_rel;
      lim = exc_lim;
      cap = acc_lim;
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        tgt[a] = held ? clampl(tgt[a] + dd[a], -lim, lim) : 0;
        frc = rmul(tgt[a] - fpos[a], k, 16) - rmul(fvel[a], c, 16);
        frc = clampl(frc, -cap, cap);
        fvel[a] = clampl(fvel[a] + rmul(frc, dt, 16), -64'sd2147483648, 64'sd2147483647);
        fpos[a] = clampl(fpos[a] + rmul(fvel[a], dt, 16), -64'sd2147483648, 64'sd2147483647);
        facc[a] = frc;
        // snap a released axis that has come to rest
        if (!held && (frc < 0 ? -frc : frc) < 66 && (fvel[a] < 0 ? -fvel[a] : fvel[a]) < 7)
        begin
          facc[a] = 0; fvel[a] = 0; fpos[a] = 0;
        end
      end
      for (int a = 0; a < 3; a++) begin
        m = facc[a] < 0 ? -facc[a] : facc[a];
        sq += m * m;
      end
      if (sq > longint'(cap) * longint'(cap)) begin
        mag = root_floor(sq);
        for (int a = 0; a < 3; a++) begin
          m = facc[a] < 0 ? -facc[a] : facc[a];
          m = m * longint'(cap) / mag;
          facc[a] = facc[a] < 0 ? -longint'(m) : longint'(m);
        end
      end
    end
    r.rest = 1;
    for (int a = 0; a < 3; a++) begin
      r.acc[a] = facc[a][31:0];
      r.pos[a] = fpos[a][31:0];
      if (fpos[a] != 0 || fvel[a] != 0 || facc[a] != 0) r.rest = 0;
    end
    return r;
  endfunction

  task automatic config_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    write_reg(idx, v);
  endtask

  task automatic load_setting(logic [31:0] kh, ch, kr, cr, el, al);
    s_tvalid <= 0;
    // no result is left pending, but allow the scaling path to finish
    while (pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    config_write(REG_HELD_K, kh);
    config_write(REG_HELD_C, ch);
    config_write(REG_REL_K, kr);
    config_write(REG_REL_C, cr);
    config_write(REG_EXC_LIM, el);
    config_write(REG_ACC_LIM, al);
    cfg_we <= 0;
  endtask

  task automatic offer_item(row_t r);
    longint dd [3];
    motion_t e;
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {r.dt, r.dz, r.dy, r.dx};
    s_tuser <= r.held;
    do @(posedge clk); while (!s_tready);
    dd[0] = r.dx; dd[1] = r.dy; dd[2] = r.dz;
    e = advance_follower(dd, r.held, r.dt);
    if (r.known && (e.acc[0] != r.ax || e.acc[1] != r.ay || e.acc[2] != r.az ||
        e.pos[0] != r.px || e.pos[1] != r.py || e.pos[2] != r.pz || e.rest != r.rest))
      $display("%0t table row disagrees with predictor", $time);
    if (r.known) begin
      e.acc[0] = r.ax; e.acc[1] = r.ay; e.acc[2] = r.az;
      e.pos[0] = r.px; e.pos[1] = r.py; e.pos[2] = r.pz; e.rest = r.rest;
    end
    pending.push_back(e);
  endtask

  function automatic row_t mk(logic [31:0] dx, dy, dz, logic h, logic [15:0] dt);
    row_t r;
    r.dx = dx; r.dy = dy; r.dz = dz; r.held = h; r.dt = dt; r.known = 0;
    return r;
  endfunction

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 65536) - 32768;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    motion_t e;
    logic [31:0] got;
    if (rst) m_tready <= 0;
    else begin
      if (m_tvalid && m_tready) begin
        if (pending.size() == 0) begin
          $display("%0t unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          e = pending.pop_front();
          for (int a = 0; a < 3; a++) begin
            got = m_tdata[32*a +: 32];
            if (got !== e.acc[a]) begin
              $display("%0t accel[%0d] expected %h actual %h", $time, a, e.acc[a], got);
              errors++;
            end
            got = m_tdata[96 + 32*a +: 32];
            if (got !== e.pos[a]) begin
              $display("%0t pos[%0d] expected %h actual %h", $time, a, e.pos[a], got);
              errors++;
            end
          end
          if (m_tuser[0] !== e.rest) begin
            $display("%0t at_rest expected %b actual %b", $time, e.rest, m_tuser[0]);
            errors++;
          end
        end
      end
      m_tready <= stall_long ? 1'b0 : ($urandom_range(0, 5) == 0 ? 1'b0 : 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || stall_long || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stall_long = 0;
    @(posedge clk);
    stall_long = 1;
    wait (!rst);
    repeat (300) @(posedge clk);
    while (s_tready) @(posedge clk);
    repeat (400) @(posedge clk);
    stall_long = 0;
  end

  initial begin
    row_t tbl [$];
    row_t r;
    logic h;
    k_held = 0; c_held = 0; k_rel = 0; c_rel = 0; exc_lim = 0; acc_lim = 0;
    for (int a = 0; a < 3; a++) begin
      tgt[a] = 0; fpos[a] = 0; fvel[a] = 0; facc[a] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset every coefficient is zero: nothing moves
    r = mk(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1, 16'hffff);
    r.known = 1; {r.ax, r.ay, r.az, r.px, r.py, r.pz} = '0; r.rest = 1;
    tbl.push_back(r);
    r = mk(0, 0, 0, 0, 0); r.known = 1; {r.ax, r.ay, r.az, r.px, r.py, r.pz} = '0; r.rest = 1;
    tbl.push_back(r);
    foreach (tbl[i]) offer_item(tbl[i]);
    tbl.delete();

    load_setting(32'h0064_0000, 32'h0014_0000, 32'h0032_0000, 32'h000e_0000,
                 32'h0002_0000, 32'h0010_0000);
    tbl.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000, 1, 16'h0444));
    tbl.push_back(mk(32'h0001_0000, 32'h0, 32'hffff_0000, 1, 16'h0444));
    tbl.push_back(mk(0, 0, 0, 1, 16'h0));
    tbl.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h0, 1, 16'hffff));
    tbl.push_back(mk(0, 0, 0, 1, 16'h0001));
    for (int i = 0; i < 12; i++) tbl.push_back(mk(0, 0, 0, 0, 16'h2000));
    tbl.push_back(mk(0, 0, 0, 0, 16'hffff));
    tbl.push_back(mk(0, 0, 0, 0, 16'h0));
    foreach (tbl[i]) offer_item(tbl[i]);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_setting(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff);
        1: load_setting($urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0040_0000),
                        $urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0040_0000),
                        $urandom, $urandom_range(1, 32'h0100_0000));
        2: load_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        3: load_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: load_setting(32'h0040_0000, 32'h0010_0000, 32'h0400_0000, 32'h0080_0000,
                        32'h0001_0000, 32'h0);
        default: load_setting(32'h0010_0000, 32'h0008_0000, 32'h0020_0000, 32'h000c_0000,
                              32'h0004_0000, 32'h0008_0000);
      endcase
      for (int n = 0; n < 300; n++) begin
        // runs of held items with random deltas, then releases settling down
        h = (n % 40) < 25 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0);
        r = mk(rand_delta(), rand_delta(), rand_delta(), h,
               $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 1) ? 0 : 16'hffff)
                                         : 16'($urandom_range(1, 16'h1000)));
        if ($urandom_range(0, 9) == 0) r.dt = 16'($urandom);
        offer_item(r);
      end
    end

    s_tvalid <= 0;
    draining = 1;
    while (pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sdf_pkg.sv
rtl/core/sdf_lane.sv
rtl/core/sdf_merge.sv
rtl/core/spring_damper_follower_core.sv
tb/spring_damper_follower_core_tb.sv
